// ===== rtl/tlbc_pkg.sv =====
// Package for the signal tower lamp controller.
// Word types, configuration register indexes, status and lamp codes.
// No dependencies.
`timescale 1ns / 1ps

package tlbc_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAIT_TIME     = 8'd0,
        CFG_LAMP_PATTERNS = 8'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_STOP      = 3'd0,
        ST_RUN       = 3'd1,
        ST_JAM       = 3'd2,
        ST_LOT_END   = 3'd3,
        ST_INIT      = 3'd4,
        ST_WARNING   = 3'd5,
        ST_LOCK      = 3'd6,
        ST_SELFCHECK = 3'd7
    } run_status_t;

    typedef enum logic [1:0] {
        CODE_OFF   = 2'd0,
        CODE_ON    = 2'd1,
        CODE_FLASH = 2'd2,
        CODE_KEEP  = 2'd3
    } lamp_code_t;

    // lamp drive bit positions
    localparam int unsigned BIT_RED    = 0;
    localparam int unsigned BIT_YELLOW = 1;
    localparam int unsigned BIT_GREEN  = 2;
    localparam int unsigned BIT_START  = 3;
    localparam int unsigned BIT_STOP   = 4;
    localparam int unsigned BIT_RESET  = 5;

    // init cycle lamp sets
    localparam logic [5:0] INIT_RED_START    = 6'b001001;
    localparam logic [5:0] INIT_YELLOW_STOP  = 6'b010010;
    localparam logic [5:0] INIT_GREEN_RESET  = 6'b100100;

    localparam logic [15:0] WAIT_TIME_RESET = 16'd500;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [2:0]  run_status;
        logic        recovering;
        logic        monitor_screen;
    } tlbc_in_t;

    typedef struct packed {
        logic       red_lamp;
        logic       yellow_lamp;
        logic       green_lamp;
        logic       start_button_lamp;
        logic       stop_button_lamp;
        logic       reset_button_lamp;
        logic [2:0] phase;
    } tlbc_out_t;

    typedef struct packed {
        logic [15:0] wait_time_ms;
        logic [47:0] lamp_patterns;
    } tlbc_cfg_t;

endpackage

// ===== rtl/tlbc_cfg_regs.sv =====
// Configuration register file: hold time and per-status lamp patterns.
// Depends on tlbc_pkg.
`timescale 1ns / 1ps

module tlbc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [tlbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tlbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tlbc_pkg::tlbc_cfg_t                 cfg
);

    tlbc_pkg::tlbc_cfg_t cfg_reg;
    tlbc_pkg::tlbc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tlbc_pkg::CFG_WAIT_TIME:     cfg_next.wait_time_ms  = cfg_data[15:0];
                tlbc_pkg::CFG_LAMP_PATTERNS: cfg_next.lamp_patterns = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wait_time_ms  <= tlbc_pkg::WAIT_TIME_RESET;
            cfg_reg.lamp_patterns <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tlbc_seq.sv =====
// Lamp sequencer: step, phase start time and lamp drives, one poll per fire.
// Depends on tlbc_pkg.
`timescale 1ns / 1ps

module tlbc_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  tlbc_pkg::tlbc_in_t   item,
    input  tlbc_pkg::tlbc_cfg_t  cfg,
    output tlbc_pkg::tlbc_out_t  result,
    output logic [2:0]           step
);

    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic [31:0] start_ms_reg;
    logic [31:0] start_ms_next;
    logic [5:0]  lamps_reg;
    logic [5:0]  lamps_next;

    logic [31:0] elapsed;
    logic        held;
    logic        is_init;
    logic        on_phase;
    logic [5:0]  pattern;

    assign elapsed = item.now_ms - start_ms_reg;
    assign held    = elapsed > {16'd0, cfg.wait_time_ms};
    assign is_init = item.run_status == tlbc_pkg::ST_INIT;
    assign on_phase = step_reg == 3'd0;
    assign pattern  = cfg.lamp_patterns[6'(item.run_status) * 6'd6 +: 6];

    function automatic logic code_drive(input logic [1:0] code, input logic cur,
                                        input logic on);
        logic v;
        v = cur;
        case (code)
            tlbc_pkg::CODE_OFF:   v = 1'b0;
            tlbc_pkg::CODE_ON:    v = 1'b1;
            tlbc_pkg::CODE_FLASH: v = on;
            default:              v = cur;
        endcase
        return v;
    endfunction

    always_comb begin
        step_next     = step_reg;
        start_ms_next = start_ms_reg;
        lamps_next    = lamps_reg;
        if (!item.monitor_screen) begin
            if (item.run_status == tlbc_pkg::ST_JAM ||
                item.run_status == tlbc_pkg::ST_WARNING) begin
                lamps_next[tlbc_pkg::BIT_STOP]  = 1'b1;
                lamps_next[tlbc_pkg::BIT_START] = 1'b0;
            end
            if (is_init) begin
                case (step_reg)
                    3'd0:       lamps_next = tlbc_pkg::INIT_RED_START;
                    3'd2, 3'd6: lamps_next = tlbc_pkg::INIT_YELLOW_STOP;
                    3'd4:       lamps_next = tlbc_pkg::INIT_GREEN_RESET;
                    default:    ;
                endcase
                if (!step_reg[0]) begin
                    start_ms_next = item.now_ms;
                    step_next     = step_reg + 3'd1;
                end else if (held) begin
                    step_next = step_reg + 3'd1;
                end
            end else if (step_reg[2]) begin
                step_next = 3'd0;
            end else if (step_reg[0]) begin
                if (held) begin
                    step_next = (step_reg == 3'd3) ? 3'd0 : step_reg + 3'd1;
                end
            end else begin
                if (item.recovering) begin
                    lamps_next[tlbc_pkg::BIT_GREEN] = on_phase;
                    lamps_next[tlbc_pkg::BIT_START] = on_phase;
                end else begin
                    lamps_next[tlbc_pkg::BIT_RED] =
                        code_drive(pattern[1:0], lamps_next[tlbc_pkg::BIT_RED], on_phase);
                    lamps_next[tlbc_pkg::BIT_YELLOW] =
                        code_drive(pattern[3:2], lamps_next[tlbc_pkg::BIT_YELLOW], on_phase);
                    lamps_next[tlbc_pkg::BIT_GREEN] =
                        code_drive(pattern[5:4], lamps_next[tlbc_pkg::BIT_GREEN], on_phase);
                end
                start_ms_next = item.now_ms;
                step_next     = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            start_ms_reg <= '0;
            lamps_reg    <= '0;
        end else if (fire) begin
            step_reg     <= step_next;
            start_ms_reg <= start_ms_next;
            lamps_reg    <= lamps_next;
        end
    end

    assign result.red_lamp          = lamps_next[tlbc_pkg::BIT_RED];
    assign result.yellow_lamp       = lamps_next[tlbc_pkg::BIT_YELLOW];
    assign result.green_lamp        = lamps_next[tlbc_pkg::BIT_GREEN];
    assign result.start_button_lamp = lamps_next[tlbc_pkg::BIT_START];
    assign result.stop_button_lamp  = lamps_next[tlbc_pkg::BIT_STOP];
    assign result.reset_button_lamp = lamps_next[tlbc_pkg::BIT_RESET];
    assign result.phase             = step_next;
    assign step                     = step_reg;

endmodule

// ===== rtl/tower_lamp_blink_controller.sv =====
// Top level of the signal tower lamp controller: input register, sequencer,
// result register and configuration registers.
// Depends on tlbc_pkg, tlbc_cfg_regs and tlbc_seq.
//
// Usage:
//   s_ channel: one poll word (time, status, recovery and monitor flags).
//   m_ channel: one result word per poll (six lamp drives and the phase).
//   cfg_ channel: register writes, index 0 hold time in ms, index 1 lamp
//   patterns; writes to other indexes are dropped. cfg_ready is always high.
// Path: an accepted poll is held in the input register, then in the result register that drives m_.
// Throughput: one poll per clock while m_ready does not hold the result. The sequencer state is read and updated
// in the single stage between the input register and the result register,
// so consecutive polls see each other's updates with no bubble.
// Reset: step, phase start time and all lamps clear, hold time 500 ms,
// patterns all zero, both channels empty.
// Stall: while m_ready is low the result word holds; one more poll can wait
// in the input register, after which s_ready drops.
`timescale 1ns / 1ps

module tower_lamp_blink_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tlbc_pkg::tlbc_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tlbc_pkg::tlbc_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tlbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                in_valid_reg;
    logic                in_valid_next;
    tlbc_pkg::tlbc_in_t  in_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    tlbc_pkg::tlbc_out_t out_reg;

    tlbc_pkg::tlbc_cfg_t cfg;
    tlbc_pkg::tlbc_out_t result;
    logic [2:0]          step;

    logic advance;
    logic fire;
    logic take;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign take      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    tlbc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlbc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (result),
        .step    (step)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_phase_tracks_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_data.phase == step)
        else $error("result phase differs from sequencer step");

    a_monitor_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_reg.monitor_screen) |=> $stable(step))
        else $error("step moved during monitor screen poll");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_high_step_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !in_reg.monitor_screen && step[2] &&
         in_reg.run_status != tlbc_pkg::ST_INIT) |=> step == 3'd0)
        else $error("out-of-range step not cleared");

endmodule
